FILE: hdl/psg_pkg.sv
// Shared types and constants of the speech gate and PCM blocker.
// Used by psg_front, psg_back and pcm_speech_gate_blocker; no dependencies.
package psg_pkg;

	localparam int SAMPLE_W  = 26;
	localparam int PCM_W     = 16;
	localparam int THR_W     = 15;
	localparam int PRE_W     = 10;
	localparam int BLK_W     = 13;
	localparam int FILL_W    = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREROLL_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RST   = 15'd327;
	localparam logic [PRE_W-1:0] PREROLL_LEN_RST = 10'd960;
	localparam logic [BLK_W-1:0] BLOCK_LEN_RST   = 13'd512;

	// block length zero selects the default, above the maximum saturates
	localparam logic [BLK_W-1:0] BLK_DEFAULT = 13'd512;
	localparam logic [BLK_W-1:0] BLK_MAX     = 13'd4096;

	// Q3.22 full scale (1.0) and the positive PCM limit
	localparam logic [SAMPLE_W-1:0] Q22_ONE = 26'd4194304;
	localparam logic [PCM_W-1:0]    PCM_POS_MAX = 16'd32767;

	// result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;
	localparam int QLW    = 3;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [PRE_W-1:0] preroll_len;
		logic [BLK_W-1:0] block_len;
	} cfg_t;

	typedef struct packed {
		logic signed [PCM_W-1:0] pcm;
		logic                    sample_valid;
		logic                    is_pad;
		logic                    block_end;
		logic                    drained;
	} result_t;

endpackage

FILE: hdl/psg_front.sv
// Front end: converts samples to PCM, gates leading silence, keeps the pending
// store and block count, and issues at most one result per item into a registered stage.
// Depends on psg_pkg.
module psg_front #(
	parameter int PENDING_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psg_pkg::cfg_t                       cfg,
	input  logic                                acc,
	input  logic                                mode,
	input  logic signed [psg_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                chunk_start,
	output logic                                res_valid,
	output psg_pkg::result_t                    res
);
	import psg_pkg::*;

	localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int SW = AW + 1;
	localparam int PRE_LIM = (1 << PRE_W) - 1;
	localparam int PRE_MAX = (PENDING_DEPTH - 1 < PRE_LIM) ? PENDING_DEPTH - 1 : PRE_LIM;

	function automatic logic signed [PCM_W-1:0] to_pcm(input logic [SAMPLE_W-1:0] v);
		logic [SAMPLE_W-1:0] mag;
		logic [PCM_W-1:0]    m;
		mag = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
		if (mag > Q22_ONE) mag = Q22_ONE;
		m = mag[22:7];
		if (v[SAMPLE_W-1]) return PCM_W'(~m + PCM_W'(1));
		if (m > PCM_POS_MAX) return PCM_POS_MAX;
		return m;
	endfunction

	logic [PCM_W-1:0] pend_mem_q [PENDING_DEPTH];

	logic              speech_q;
	logic [AW-1:0]     rp_q;
	logic [CW-1:0]     count_q;
	logic [FILL_W-1:0] fill_q;

	logic              valid_s1;
	logic              sel_mem_s1;
	result_t           res_s1;
	logic [PCM_W-1:0]  rdata_s1;

	logic signed [PCM_W-1:0] pcm;
	logic [PCM_W-1:0]        pcm_abs;
	logic [CW-1:0]           pre;
	logic [BLK_W-1:0]        eff_blk;
	logic [CW-1:0]           cnt0, cnt1, cnt_d;
	logic [SW-1:0]           wsum;
	logic [AW-1:0]           wp, rp_inc, rp_d;
	logic                    wr_en, rd_en, pop, has_res, pad, adv, byp, speech_d;
	logic [BLK_W-1:0]        fill_inc;
	logic                    blk_end;
	logic [FILL_W-1:0]       fill_d;
	logic                    drained;

	always_comb begin
		pcm     = to_pcm(sample_in);
		pcm_abs = pcm[PCM_W-1] ? (~pcm + PCM_W'(1)) : pcm;
		pre     = (int'(cfg.preroll_len) > PRE_MAX) ? CW'(PRE_MAX) : CW'(cfg.preroll_len);
		if (cfg.block_len == '0)         eff_blk = BLK_DEFAULT;
		else if (cfg.block_len > BLK_MAX) eff_blk = BLK_MAX;
		else                              eff_blk = cfg.block_len;
	end

	always_comb begin
		// history restarts on a new chunk before speech, and is dropped on a drain before speech
		cnt0 = ((!speech_q && !mode && chunk_start) || (!speech_q && mode)) ? '0 : count_q;
		cnt1 = cnt0 + CW'(1);
		wsum = SW'(rp_q) + SW'(cnt0);
		wp   = (wsum >= SW'(PENDING_DEPTH)) ? AW'(wsum - SW'(PENDING_DEPTH)) : AW'(wsum);
		rp_inc = (rp_q == AW'(PENDING_DEPTH - 1)) ? '0 : rp_q + AW'(1);

		wr_en    = 1'b0;
		rd_en    = 1'b0;
		pop      = 1'b0;
		has_res  = 1'b0;
		pad      = 1'b0;
		adv      = 1'b0;
		byp      = 1'b0;
		speech_d = speech_q;
		cnt_d    = cnt0;
		if (!mode) begin
			wr_en = 1'b1;
			if (!speech_q && (pcm_abs <= PCM_W'(cfg.threshold))) begin
				if (cnt1 > pre) pop = 1'b1;
				else            cnt_d = cnt1;
			end else begin
				speech_d = 1'b1;
				has_res  = 1'b1;
				pop      = 1'b1;
				adv      = 1'b1;
				// empty history: the sample leaves in the same step it arrives
				if (cnt0 == '0) byp = 1'b1;
				else            rd_en = 1'b1;
			end
		end else begin
			has_res = 1'b1;
			if (cnt0 != '0) begin
				pop   = 1'b1;
				rd_en = 1'b1;
				adv   = 1'b1;
				cnt_d = cnt0 - CW'(1);
			end else if (fill_q != '0) begin
				pad = 1'b1;
				adv = 1'b1;
			end
		end

		fill_inc = BLK_W'(fill_q) + BLK_W'(1);
		blk_end  = adv && (fill_inc >= eff_blk);
		fill_d   = !adv ? fill_q : (blk_end ? '0 : FILL_W'(fill_inc));
		rp_d     = pop ? rp_inc : rp_q;
		drained  = mode && (cnt_d == '0) && (fill_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speech_q <= 1'b0;
			rp_q     <= '0;
			count_q  <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc && has_res;
			if (acc) begin
				if (drained) begin
					speech_q <= 1'b0;
					rp_q     <= '0;
					count_q  <= '0;
					fill_q   <= '0;
				end else begin
					speech_q <= speech_d;
					rp_q     <= rp_d;
					count_q  <= cnt_d;
					fill_q   <= fill_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sel_mem_s1          <= rd_en;
			res_s1.pcm          <= byp ? pcm : '0;
			res_s1.sample_valid <= mode ? ((cnt0 != '0) || pad) : 1'b1;
			res_s1.is_pad       <= pad;
			res_s1.block_end    <= blk_end;
			res_s1.drained      <= drained;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wr_en) pend_mem_q[wp] <= pcm;
		if (acc && rd_en) rdata_s1 <= pend_mem_q[rp_q];
	end

	always_comb begin
		res = res_s1;
		if (sel_mem_s1) res.pcm = rdata_s1;
	end

	assign res_valid = valid_s1;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(PENDING_DEPTH - 1))
		else $error("pending count above store depth");

	a_no_fill_before_speech: assert property (@(posedge clk) disable iff (!arst_n)
		!speech_q |-> (fill_q == '0))
		else $error("block open while still gating silence");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && drained) |=> (count_q == '0 && !speech_q && rp_q == '0 && fill_q == '0))
		else $error("state not cleared after final drain result");
`endif

endmodule

FILE: hdl/psg_back.sv
// Back end: short result queue that decouples the front from output stalls
// and drives the result channel from its head entry. Depends on psg_pkg.
module psg_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  psg_pkg::result_t          push_data,
	output logic                      res_valid,
	input  logic                      res_stall,
	output psg_pkg::result_t          head,
	output logic [psg_pkg::QLW-1:0]   level
);
	import psg_pkg::*;

	result_t          entry_q [QDEPTH];
	logic [QAW-1:0]   wp_q, rp_q;
	logic [QLW-1:0]   level_q;
	logic             pop;

	assign pop       = (level_q != '0) && !res_stall;
	assign res_valid = (level_q != '0);
	assign head      = entry_q[rp_q];
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QAW'(1);
			if (pop)  rp_q <= rp_q + QAW'(1);
			level_q <= level_q + QLW'(push) - QLW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wp_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < QLW'(QDEPTH)))
		else $error("result pushed into full queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= QLW'(QDEPTH))
		else $error("queue level out of range");

	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && level_q == '0) |=> (level_q == QLW'(1)))
		else $error("result into empty queue not visible");
`endif

endmodule

FILE: hdl/pcm_speech_gate_blocker.sv
// Speech gate and PCM blocker, top level; uses psg_pkg, psg_front, psg_back.
// Each result is registered in psg_front and then queued in psg_back before the output;
// quiet samples before speech give no result. Throughput: one item per cycle while
// item_stall is low, set by the single write and single read port of the pending store.
// Reset: asynchronous, clears gate state, pointers, block count and queue; the
// pending store has no reset and needs no clearing pass.
module pcm_speech_gate_blocker #(
	parameter int PENDING_DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 mode,
	input  logic signed [psg_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 chunk_start,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [psg_pkg::PCM_W-1:0]     pcm_out,
	output logic                                 sample_valid,
	output logic                                 is_pad,
	output logic                                 block_end,
	output logic                                 drained,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [psg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [psg_pkg::CFG_DW-1:0]           cfg_data
);
	import psg_pkg::*;

	cfg_t           cfg_q;
	logic           acc;
	logic           front_valid;
	result_t        front_res;
	result_t        head;
	logic [QLW-1:0] level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THRESHOLD_RST;
			cfg_q.preroll_len <= PREROLL_LEN_RST;
			cfg_q.block_len   <= BLOCK_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data[THR_W-1:0];
				CFG_PREROLL_LEN: cfg_q.preroll_len <= cfg_data[PRE_W-1:0];
				CFG_BLOCK_LEN:   cfg_q.block_len   <= cfg_data[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	// hold input while queued results plus the one in flight could fill the queue
	assign item_stall = (level + QLW'(front_valid)) >= QLW'(QDEPTH);
	assign acc        = item_valid && !item_stall;

	psg_front #(
		.PENDING_DEPTH(PENDING_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.acc        (acc),
		.mode       (mode),
		.sample_in  (sample_in),
		.chunk_start(chunk_start),
		.res_valid  (front_valid),
		.res        (front_res)
	);

	psg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_valid),
		.push_data(front_res),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.head     (head),
		.level    (level)
	);

	assign pcm_out      = head.pcm;
	assign sample_valid = head.sample_valid;
	assign is_pad       = head.is_pad;
	assign block_end    = head.block_end;
	assign drained      = head.drained;

endmodule

FILE: tb/sv/psg_tb_pkg.sv
// Codes shared by the checker and the top of the speech gate testbench.
// Depends on psg_pkg for the width of the register index.
package psg_tb_pkg;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_DRAIN  = 1'b1;

	// index 3 maps to no register; writes to it must change nothing
	localparam logic [psg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

endpackage

FILE: tb/sv/psg_checker.sv
// Checker of the speech gate and PCM blocker: watches the item, result and register
// channels, predicts every result and compares it. Depends on psg_pkg and psg_tb_pkg.
module psg_checker #(
	parameter int DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	input  logic                                 item_stall,
	input  logic                                 mode,
	input  logic signed [psg_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 chunk_start,
	input  logic                                 res_valid,
	input  logic                                 res_stall,
	input  logic signed [psg_pkg::PCM_W-1:0]     pcm_out,
	input  logic                                 sample_valid,
	input  logic                                 is_pad,
	input  logic                                 block_end,
	input  logic                                 drained,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [psg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [psg_pkg::CFG_DW-1:0]           cfg_data,
	output int                                   fail_count,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import psg_pkg::*;
	import psg_tb_pkg::*;

	localparam int FRAC_SHIFT = 7;

	logic [THR_W-1:0] thr;
	logic [PRE_W-1:0] pre;
	logic [BLK_W-1:0] blk;

	bit               talking;
	logic [PCM_W-1:0] hist [DEPTH];
	int unsigned      rd;
	int unsigned      cnt;
	int               fill;
	int               errs;
	result_t          want_q [$];

	function automatic logic signed [PCM_W-1:0] q22_to_pcm(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] mag;
		u = s;
		mag = s[SAMPLE_W-1] ? -u : u;
		if (mag > Q22_ONE)
			mag = Q22_ONE;
		mag = mag >> FRAC_SHIFT;
		if (s[SAMPLE_W-1])
			return -mag[PCM_W-1:0];
		if (mag > PCM_POS_MAX)
			mag = PCM_POS_MAX;
		return mag[PCM_W-1:0];
	endfunction

	function automatic void hist_push(input logic [PCM_W-1:0] v);
		hist[(rd + cnt) % DEPTH] = v;
		cnt++;
	endfunction

	function automatic logic [PCM_W-1:0] hist_pop();
		logic [PCM_W-1:0] v;
		v = hist[rd];
		rd = (rd + 1) % DEPTH;
		cnt--;
		return v;
	endfunction

	// advance the open block, true when this sample closes it
	function automatic bit count_block();
		int eff;
		eff = (blk == 0) ? BLK_DEFAULT : ((blk > BLK_MAX) ? BLK_MAX : blk);
		fill++;
		if (fill >= eff) begin
			fill = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_gate();
		talking = 1'b0;
		rd = 0;
		cnt = 0;
		fill = 0;
	endfunction

	// one accepted item; true when it causes a result
	function automatic bit gate_step(input logic m, input logic signed [SAMPLE_W-1:0] s,
			input logic cs, output result_t r);
		logic signed [PCM_W-1:0] pcm;
		int mag;
		int pre_cap;
		r = '0;
		pre_cap = (pre > DEPTH - 1) ? DEPTH - 1 : pre;
		if (m == MODE_SAMPLE) begin
			pcm = q22_to_pcm(s);
			if (!talking) begin
				mag = (pcm < 0) ? -int'(pcm) : int'(pcm);
				if (cs)
					cnt = 0;
				hist_push(pcm);
				if (mag <= thr) begin
					if (cnt > pre_cap)
						void'(hist_pop());
					return 1'b0;
				end
				talking = 1'b1;
			end else
				hist_push(pcm);
			r.pcm = hist_pop();
			r.sample_valid = 1'b1;
			r.block_end = count_block();
			return 1'b1;
		end
		if (!talking)
			cnt = 0;
		if (cnt > 0) begin
			r.pcm = hist_pop();
			r.sample_valid = 1'b1;
			r.block_end = count_block();
		end else if (fill > 0) begin
			r.sample_valid = 1'b1;
			r.is_pad = 1'b1;
			r.block_end = count_block();
		end
		if (cnt == 0 && fill == 0) begin
			r.drained = 1'b1;
			clear_gate();
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		result_t w;
		if (!arst_n) begin
			thr = THRESHOLD_RST;
			pre = PREROLL_LEN_RST;
			blk = BLOCK_LEN_RST;
			clear_gate();
			want_q.delete();
			errs = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_THRESHOLD:   thr = cfg_data[THR_W-1:0];
					CFG_PREROLL_LEN: pre = cfg_data[PRE_W-1:0];
					CFG_BLOCK_LEN:   blk = cfg_data[BLK_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (gate_step(mode, sample_in, chunk_start, r))
					want_q.push_back(r);
			end
			if (res_valid && !res_stall) begin
				if (want_q.size() == 0) begin
					errs++;
					$display("%0t: expected no result, actual %0d %0b %0b %0b %0b",
						$time, pcm_out, sample_valid, is_pad, block_end, drained);
				end else begin
					w = want_q.pop_front();
					check_field("pcm_out", w.pcm, pcm_out);
					check_field("sample_valid", w.sample_valid, sample_valid);
					check_field("is_pad", w.is_pad, is_pad);
					check_field("block_end", w.block_end, block_end);
					check_field("drained", w.drained, drained);
				end
			end
			fail_count <= errs;
			outstanding <= want_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_pcm_speech_gate_blocker.sv
// Top of the speech gate and PCM blocker testbench: clock, reset, stimulus and verdict.
// Depends on psg_pkg, psg_tb_pkg, psg_checker and the block pcm_speech_gate_blocker.
module tb_pcm_speech_gate_blocker;
	timeunit 1ns;
	timeprecision 1ps;
	import psg_pkg::*;
	import psg_tb_pkg::*;

	localparam int DEPTH          = 1024;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CAP      = 6000;
	localparam int THR_MAX        = 32767;
	localparam int PHASE_ITEMS    = 20;

	typedef enum int {LVL_QUIET, LVL_LOUD, LVL_ANY} level_e;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       item_valid;
	logic                       item_stall;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       chunk_start;
	logic                       res_valid;
	logic                       res_stall = 1'b0;
	logic signed [PCM_W-1:0]    pcm_out;
	logic                       sample_valid;
	logic                       is_pad;
	logic                       block_end;
	logic                       drained;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DW-1:0]          cfg_data;

	int fail_count;
	int outstanding;
	int rx_hold = 0;
	int drained_cnt = 0;
	int idle_cycles = 0;
	int sent = 0;
	bit tx_calm;
	bit rx_calm;
	int cur_thr;

	pcm_speech_gate_blocker #(.PENDING_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .sample_in(sample_in), .chunk_start(chunk_start),
		.res_valid(res_valid), .res_stall(res_stall),
		.pcm_out(pcm_out), .sample_valid(sample_valid), .is_pad(is_pad),
		.block_end(block_end), .drained(drained),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	psg_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .sample_in(sample_in), .chunk_start(chunk_start),
		.res_valid(res_valid), .res_stall(res_stall),
		.pcm_out(pcm_out), .sample_valid(sample_valid), .is_pad(is_pad),
		.block_end(block_end), .drained(drained),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: draw a stall length for every result taken
	always @(posedge clk or negedge arst_n) begin
		int nxt;
		if (!arst_n) begin
			res_stall <= 1'b0;
			rx_hold <= 0;
			drained_cnt <= 0;
		end else if (res_valid && !res_stall) begin
			if (drained)
				drained_cnt <= drained_cnt + 1;
			nxt = rx_calm ? 0 : $urandom_range(0, 10);
			rx_hold <= nxt;
			res_stall <= (nxt != 0);
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			res_stall <= (rx_hold != 1);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic send_item(input logic m, input logic [SAMPLE_W-1:0] s, input logic cs);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		sample_in <= s;
		chunk_start <= cs;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// random bits above each register's width must be dropped by the block
	task automatic configure(input int thr, input int pre, input int blk);
		cfg_write(CFG_THRESHOLD, CFG_DW'(thr) | (CFG_DW'($urandom) << THR_W));
		cfg_write(CFG_PREROLL_LEN, CFG_DW'(pre) | (CFG_DW'($urandom) << PRE_W));
		cfg_write(CFG_BLOCK_LEN, CFG_DW'(blk) | (CFG_DW'($urandom) << BLK_W));
		if ($urandom_range(0, 2) == 0)
			cfg_write(CFG_UNUSED, CFG_DW'($urandom));
		cfg_valid <= 1'b0;
		cur_thr = thr;
	endtask

	// hold off until every expected result is in, then cover the pipeline
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// drain until the block reports it is empty
	task automatic drain_out();
		int seen;
		int n;
		settle();
		seen = drained_cnt;
		n = 0;
		while (drained_cnt == seen && n < DRAIN_CAP) begin
			send_item(MODE_DRAIN, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
			n++;
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input level_e lvl);
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		bit neg;
		neg = 1'($urandom_range(0, 1));
		case (lvl)
			LVL_QUIET: begin
				hi = (cur_thr + 1) * 128 - 1;
				if (hi > int'(Q22_ONE) - 1)
					hi = int'(Q22_ONE) - 1;
				mag = $urandom_range(0, hi);
			end
			LVL_LOUD: begin
				lo = (cur_thr + 1) * 128;
				// positive samples saturate at 32767, so only negative ones can be loud
				if (lo >= int'(Q22_ONE))
					neg = 1'b1;
				hi = neg ? 33554432 : 33554431;
				if ($urandom_range(0, 1) == 0)
					hi = int'(Q22_ONE);
				mag = $urandom_range(lo, hi);
			end
			default: begin
				case ($urandom_range(0, 5))
					0: return 26'h1FFFFFF;
					1: return 26'h2000000;
					2: return neg ? -Q22_ONE : Q22_ONE;
					default: return SAMPLE_W'($urandom);
				endcase
			end
		endcase
		return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
	endfunction

	// quiet lead-in, usually a loud onset, a mixed tail with stray drains, then drain
	task automatic run_request(input int n_quiet, input int n_tail);
		int k;
		for (k = 0; k < n_quiet; k++)
			send_item(MODE_SAMPLE, pick_sample(LVL_QUIET), k == 0 || $urandom_range(0, 7) == 0);
		if ($urandom_range(0, 6) != 0)
			send_item(MODE_SAMPLE, pick_sample(LVL_LOUD), $urandom_range(0, 3) == 0);
		for (k = 0; k < n_tail; k++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(MODE_DRAIN, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
			else
				send_item(MODE_SAMPLE, pick_sample(level_e'($urandom_range(0, 2))),
					$urandom_range(0, 7) == 0);
		end
		drain_out();
	endtask

	initial begin
		int ph;
		int start;
		int nq;
		int nt;
		item_valid <= 1'b0;
		mode <= MODE_SAMPLE;
		sample_in <= '0;
		chunk_start <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= '0;
		cur_thr = THRESHOLD_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		configure(100, 3, 4);
		send_item(MODE_DRAIN, 26'd0, 1'b1);          // nothing heard: drained at once
		send_item(MODE_SAMPLE, 26'd0, 1'b1);
		send_item(MODE_SAMPLE, -26'sd12800, 1'b0);   // |pcm| equal to threshold stays quiet
		send_item(MODE_SAMPLE, 26'd12927, 1'b0);     // truncates to 100
		send_item(MODE_SAMPLE, -26'sd127, 1'b0);     // truncates toward zero
		send_item(MODE_SAMPLE, 26'd5, 1'b0);         // history over preroll, drop oldest
		send_item(MODE_SAMPLE, 26'd1000, 1'b1);      // new chunk drops the history
		send_item(MODE_SAMPLE, 26'd12928, 1'b0);     // first loud sample
		send_item(MODE_SAMPLE, Q22_ONE, 1'b0);
		send_item(MODE_SAMPLE, 26'h1FFFFFF, 1'b1);   // chunk start after speech is ignored
		send_item(MODE_SAMPLE, 26'h2000000, 1'b0);
		send_item(MODE_SAMPLE, -Q22_ONE, 1'b0);
		send_item(MODE_SAMPLE, Q22_ONE - 26'd1, 1'b0);
		send_item(MODE_SAMPLE, -26'sd128, 1'b0);
		send_item(MODE_SAMPLE, 26'd127, 1'b0);
		send_item(MODE_SAMPLE, 26'h0AAAAAA, 1'b0);
		send_item(MODE_SAMPLE, 26'h3555555, 1'b0);
		drain_out();

		for (ph = 0; ph < 12; ph++) begin
			settle();
			case (ph)
				0: configure(0, 0, 1);
				1: configure(THR_MAX, 1023, $urandom_range(1, 24));
				2: configure(1, 1022, 3);
				3: configure($urandom_range(0, THR_MAX), 1, 2);
				4: configure(THRESHOLD_RST, PREROLL_LEN_RST, 16);
				5: configure($urandom_range(50, 3000), $urandom_range(0, 30),
					$urandom_range(1, 24));
				default: configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, THR_MAX)
						: $urandom_range(0, 2000),
					$urandom_range(0, 24), $urandom_range(1, 24));
			endcase
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			start = sent;
			while (sent - start < PHASE_ITEMS) begin
				nq = $urandom_range(0, 12);
				nt = $urandom_range(0, 20);
				run_request(nq, nt);
				if ($urandom_range(0, 2) == 0)
					tx_calm = !tx_calm;
			end
		end

		settle();
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: pcm_speech_gate_blocker.f
hdl/psg_pkg.sv
hdl/psg_front.sv
hdl/psg_back.sv
hdl/pcm_speech_gate_blocker.sv
tb/sv/psg_tb_pkg.sv
tb/sv/psg_checker.sv
tb/sv/tb_pcm_speech_gate_blocker.sv
